// ===== hw/rtl/owb_pkg.sv =====
`timescale 1ns / 1ps

package owb_pkg;

   localparam int TIMER_BITS = 16;
   localparam int REG_BITS = 16;
   localparam int READ_LOW_TICKS = 1;
   localparam int BYTE_BITS = 8;
   localparam int COUNT_BITS = 4;
   localparam int CSR_INDEX_BITS = 3;

   typedef enum logic [1:0] {
      OP_NONE  = 2'd0,
      OP_RESET = 2'd1,
      OP_WRITE = 2'd2,
      OP_READ  = 2'd3
   } owb_op_type;

   typedef enum logic [3:0] {
      PHASE_IDLE      = 4'd0,
      PHASE_RST_LOW   = 4'd1,
      PHASE_PRES_WAIT = 4'd2,
      PHASE_PRES_WIN  = 4'd3,
      PHASE_W_LOW     = 4'd4,
      PHASE_W_HIGH    = 4'd5,
      PHASE_R_LOW     = 4'd6,
      PHASE_R_SAMPLE  = 4'd7,
      PHASE_R_TAIL    = 4'd8
   } owb_phase_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_RESET_LOW     = 3'd0,
      CSR_PRESENCE_WAIT = 3'd1,
      CSR_PRESENCE_WIN  = 3'd2,
      CSR_WRITE_ZERO    = 3'd3,
      CSR_WRITE_ONE_LOW = 3'd4,
      CSR_WRITE_ONE_HI  = 3'd5,
      CSR_READ_SAMPLE   = 3'd6,
      CSR_READ_TAIL     = 3'd7
   } owb_csr_index_type;

   localparam logic [REG_BITS-1:0] RESET_LOW_DEFAULT      = 16'd497;
   localparam logic [REG_BITS-1:0] PRESENCE_WAIT_DEFAULT  = 16'd61;
   localparam logic [REG_BITS-1:0] PRESENCE_WIN_DEFAULT   = 16'd489;
   localparam logic [REG_BITS-1:0] WRITE_ZERO_DEFAULT     = 16'd81;
   localparam logic [REG_BITS-1:0] WRITE_ONE_LOW_DEFAULT  = 16'd10;
   localparam logic [REG_BITS-1:0] WRITE_ONE_HIGH_DEFAULT = 16'd81;
   localparam logic [REG_BITS-1:0] READ_SAMPLE_DEFAULT    = 16'd10;
   localparam logic [REG_BITS-1:0] READ_TAIL_DEFAULT      = 16'd61;

   typedef struct packed {
      logic [REG_BITS-1:0] reset_low_ticks;
      logic [REG_BITS-1:0] presence_wait_ticks;
      logic [REG_BITS-1:0] presence_window_ticks;
      logic [REG_BITS-1:0] write_zero_low_ticks;
      logic [REG_BITS-1:0] write_one_low_ticks;
      logic [REG_BITS-1:0] write_one_high_ticks;
      logic [REG_BITS-1:0] read_sample_ticks;
      logic [REG_BITS-1:0] read_tail_ticks;
   } owb_timing_type;

   typedef struct packed {
      owb_op_type           opcode;
      logic [BYTE_BITS-1:0] write_data;
      logic                 line_level;
      logic                 tick;
   } owb_req_type;

   typedef struct packed {
      logic                 drive_low;
      logic                 busy_res;
      logic                 done_res;
      logic [BYTE_BITS-1:0] read_byte;
      logic                 presence;
      logic                 rejected;
   } owb_rsp_type;

endpackage

// ===== hw/rtl/owb_csr.sv =====
`timescale 1ns / 1ps

module owb_csr (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     csr_write_en,
   input  logic [owb_pkg::CSR_INDEX_BITS-1:0]       csr_index,
   input  logic [owb_pkg::REG_BITS-1:0]             csr_write_data,
   output owb_pkg::owb_timing_type                  timing
);

   owb_pkg::owb_timing_type timing_ff;
   owb_pkg::owb_timing_type timing_in;

   always_comb begin
      timing_in = timing_ff;
      if (csr_write_en) begin
         case (owb_pkg::owb_csr_index_type'(csr_index))
            owb_pkg::CSR_RESET_LOW:     timing_in.reset_low_ticks = csr_write_data;
            owb_pkg::CSR_PRESENCE_WAIT: timing_in.presence_wait_ticks = csr_write_data;
            owb_pkg::CSR_PRESENCE_WIN:  timing_in.presence_window_ticks = csr_write_data;
            owb_pkg::CSR_WRITE_ZERO:    timing_in.write_zero_low_ticks = csr_write_data;
            owb_pkg::CSR_WRITE_ONE_LOW: timing_in.write_one_low_ticks = csr_write_data;
            owb_pkg::CSR_WRITE_ONE_HI:  timing_in.write_one_high_ticks = csr_write_data;
            owb_pkg::CSR_READ_SAMPLE:   timing_in.read_sample_ticks = csr_write_data;
            owb_pkg::CSR_READ_TAIL:     timing_in.read_tail_ticks = csr_write_data;
            default:                    timing_in = timing_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timing_ff.reset_low_ticks       <= owb_pkg::RESET_LOW_DEFAULT;
         timing_ff.presence_wait_ticks   <= owb_pkg::PRESENCE_WAIT_DEFAULT;
         timing_ff.presence_window_ticks <= owb_pkg::PRESENCE_WIN_DEFAULT;
         timing_ff.write_zero_low_ticks  <= owb_pkg::WRITE_ZERO_DEFAULT;
         timing_ff.write_one_low_ticks   <= owb_pkg::WRITE_ONE_LOW_DEFAULT;
         timing_ff.write_one_high_ticks  <= owb_pkg::WRITE_ONE_HIGH_DEFAULT;
         timing_ff.read_sample_ticks     <= owb_pkg::READ_SAMPLE_DEFAULT;
         timing_ff.read_tail_ticks       <= owb_pkg::READ_TAIL_DEFAULT;
      end else begin
         timing_ff <= timing_in;
      end
   end

   assign timing = timing_ff;

endmodule

// ===== hw/rtl/owb_core.sv =====
`timescale 1ns / 1ps

module owb_core (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step,
   input  owb_pkg::owb_req_type    req,
   input  owb_pkg::owb_timing_type timing,
   output owb_pkg::owb_rsp_type    rsp
);

   localparam int TB = owb_pkg::TIMER_BITS;
   localparam int BB = owb_pkg::BYTE_BITS;
   localparam int CB = owb_pkg::COUNT_BITS;
   localparam logic [TB-1:0] READ_LOW = TB'(owb_pkg::READ_LOW_TICKS);
   localparam logic [TB-1:0] ONE_TICK = TB'(1);
   localparam logic [CB-1:0] FULL_BYTE = CB'(BB);

   owb_pkg::owb_phase_type phase_ff, phase_in;
   logic [TB-1:0]          timer_ff, timer_in;
   logic [BB-1:0]          shift_ff, shift_in;
   logic [CB-1:0]          bits_ff, bits_in;
   owb_pkg::owb_op_type    kind_ff, kind_in;
   logic                   pres_ff, pres_in;
   logic                   done_in;
   logic                   rej_in;
   logic                   timer_out;
   logic                   last_bit;

   assign timer_out = (timer_ff[TB-1:1] == '0);
   assign last_bit = (bits_ff <= CB'(1));

   // Next-state logic: one item is one clock of the bus master.
   always_comb begin
      phase_in = phase_ff;
      timer_in = timer_ff;
      shift_in = shift_ff;
      bits_in  = bits_ff;
      kind_in  = kind_ff;
      pres_in  = pres_ff;
      done_in  = 1'b0;
      rej_in   = 1'b0;
      if (phase_ff == owb_pkg::PHASE_IDLE) begin
         case (req.opcode)
            owb_pkg::OP_RESET: begin
               kind_in  = req.opcode;
               pres_in  = 1'b0;
               phase_in = owb_pkg::PHASE_RST_LOW;
               timer_in = TB'(timing.reset_low_ticks);
            end
            owb_pkg::OP_WRITE: begin
               kind_in  = req.opcode;
               shift_in = req.write_data;
               bits_in  = FULL_BYTE;
               phase_in = owb_pkg::PHASE_W_LOW;
               timer_in = req.write_data[0] ? TB'(timing.write_one_low_ticks)
                                            : TB'(timing.write_zero_low_ticks);
            end
            owb_pkg::OP_READ: begin
               kind_in  = req.opcode;
               shift_in = '0;
               bits_in  = FULL_BYTE;
               phase_in = owb_pkg::PHASE_R_LOW;
               timer_in = READ_LOW;
            end
            default: phase_in = owb_pkg::PHASE_IDLE;
         endcase
      end else begin
         rej_in = (req.opcode != owb_pkg::OP_NONE);
         if (phase_ff == owb_pkg::PHASE_PRES_WIN && !req.line_level) begin
            pres_in = 1'b1;
         end
         if (req.tick && !timer_out) begin
            timer_in = timer_ff - ONE_TICK;
         end else if (req.tick) begin
            case (phase_ff)
               owb_pkg::PHASE_RST_LOW: begin
                  phase_in = owb_pkg::PHASE_PRES_WAIT;
                  timer_in = TB'(timing.presence_wait_ticks);
               end
               owb_pkg::PHASE_PRES_WAIT: begin
                  phase_in = owb_pkg::PHASE_PRES_WIN;
                  timer_in = TB'(timing.presence_window_ticks);
               end
               owb_pkg::PHASE_PRES_WIN: begin
                  phase_in = owb_pkg::PHASE_IDLE;
                  timer_in = '0;
                  done_in  = 1'b1;
               end
               owb_pkg::PHASE_W_LOW: begin
                  // A zero slot recovers for a single released tick.
                  phase_in = owb_pkg::PHASE_W_HIGH;
                  timer_in = shift_ff[0] ? TB'(timing.write_one_high_ticks) : ONE_TICK;
               end
               owb_pkg::PHASE_W_HIGH: begin
                  shift_in = {1'b0, shift_ff[BB-1:1]};
                  if (last_bit) begin
                     bits_in  = '0;
                     phase_in = owb_pkg::PHASE_IDLE;
                     timer_in = '0;
                     done_in  = 1'b1;
                  end else begin
                     bits_in  = bits_ff - CB'(1);
                     phase_in = owb_pkg::PHASE_W_LOW;
                     timer_in = shift_ff[1] ? TB'(timing.write_one_low_ticks)
                                            : TB'(timing.write_zero_low_ticks);
                  end
               end
               owb_pkg::PHASE_R_LOW: begin
                  phase_in = owb_pkg::PHASE_R_SAMPLE;
                  timer_in = TB'(timing.read_sample_ticks);
               end
               owb_pkg::PHASE_R_SAMPLE: begin
                  shift_in = {req.line_level, shift_ff[BB-1:1]};
                  phase_in = owb_pkg::PHASE_R_TAIL;
                  timer_in = TB'(timing.read_tail_ticks);
               end
               owb_pkg::PHASE_R_TAIL: begin
                  if (last_bit) begin
                     bits_in  = '0;
                     phase_in = owb_pkg::PHASE_IDLE;
                     timer_in = '0;
                     done_in  = 1'b1;
                  end else begin
                     bits_in  = bits_ff - CB'(1);
                     phase_in = owb_pkg::PHASE_R_LOW;
                     timer_in = READ_LOW;
                  end
               end
               default: begin
                  phase_in = owb_pkg::PHASE_IDLE;
                  timer_in = '0;
               end
            endcase
         end
      end
   end

   // Result fields reflect the state after this item's update.
   always_comb begin
      rsp.drive_low = (phase_in == owb_pkg::PHASE_RST_LOW) ||
                      (phase_in == owb_pkg::PHASE_W_LOW) ||
                      (phase_in == owb_pkg::PHASE_R_LOW);
      rsp.busy_res  = (phase_in != owb_pkg::PHASE_IDLE);
      rsp.done_res  = done_in;
      rsp.read_byte = (phase_in == owb_pkg::PHASE_IDLE && kind_in == owb_pkg::OP_READ)
                      ? shift_in : '0;
      rsp.presence  = pres_in;
      rsp.rejected  = rej_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= owb_pkg::PHASE_IDLE;
         timer_ff <= '0;
         shift_ff <= '0;
         bits_ff  <= '0;
         kind_ff  <= owb_pkg::OP_NONE;
         pres_ff  <= 1'b0;
      end else if (step) begin
         phase_ff <= phase_in;
         timer_ff <= timer_in;
         shift_ff <= shift_in;
         bits_ff  <= bits_in;
         kind_ff  <= kind_in;
         pres_ff  <= pres_in;
      end
   end

   a_bits_range: assert property (@(posedge clock) disable iff (reset)
      bits_ff <= FULL_BYTE)
      else $error("bit count out of range");

   a_reject_only_busy: assert property (@(posedge clock) disable iff (reset)
      step && rej_in |-> phase_ff != owb_pkg::PHASE_IDLE)
      else $error("command rejected while idle");

   a_idle_timer: assert property (@(posedge clock) disable iff (reset)
      step && done_in |=> timer_ff == '0 && phase_ff == owb_pkg::PHASE_IDLE)
      else $error("finished operation left timer or phase set");

endmodule

// ===== hw/rtl/one_wire_bus_master.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Ports                               Payload
// request   in         req_valid, req_stall, req_data      owb_req_type
// response  out        rsp_valid, rsp_stall, rsp_data      owb_rsp_type
// config    in         csr_write_en, csr_index, csr_write_data  (write only)
//
// Each item is one clock of the bus master and yields one result item.
// An item is held in the input register, and the core updates its state
// on the way to the result register. One item a cycle is taken while the
// response side does not stall; a stall holds the result register and the
// input register. Reset is synchronous, loading the default timings at once.

module one_wire_bus_master (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  owb_pkg::owb_req_type               req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output owb_pkg::owb_rsp_type               rsp_data,
   input  logic                               csr_write_en,
   input  logic [owb_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [owb_pkg::REG_BITS-1:0]       csr_write_data
);

   owb_pkg::owb_timing_type timing;
   owb_pkg::owb_rsp_type    core_rsp;

   logic                 in_valid_ff, in_valid_in;
   owb_pkg::owb_req_type in_data_ff;
   logic                 out_valid_ff, out_valid_in;
   owb_pkg::owb_rsp_type out_data_ff;
   logic                 advance;
   logic                 req_accept;

   // The core steps when it holds an item and the result register is free or being emptied.
   assign advance    = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall  = in_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;

   assign in_valid_in  = req_accept || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   owb_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .timing         (timing)
   );

   owb_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .req    (in_data_ff),
      .timing (timing),
      .rsp    (core_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= core_rsp;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_data_ff))
      else $error("input item lost while the core was held");

   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_data_ff.done_res |-> !out_data_ff.busy_res)
      else $error("finish pulse while still busy");

   a_byte_only_idle: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_data_ff.read_byte != '0 |-> !out_data_ff.busy_res)
      else $error("read byte shown during an operation");

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
   import owb_pkg::*;

   localparam int WATCHDOG_LIMIT = 1000;
   localparam int MAX_REPORTS = 40;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   owb_req_type                 req_data = '0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   owb_rsp_type                 rsp_data;
   logic                        csr_write_en = 1'b0;
   logic [CSR_INDEX_BITS-1:0]   csr_index = '0;
   logic [REG_BITS-1:0]         csr_write_data = '0;

   one_wire_bus_master u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   always #5 clock = ~clock;

   // Shadow copy of the bus master state, advanced once per accepted item.
   owb_phase_type       ph;
   logic [15:0]         slot_left;
   logic [7:0]          shreg;
   logic [3:0]          bits_rem;
   owb_op_type          last_op;
   logic                pres_seen;
   logic [15:0]         timing [0:7];

   owb_rsp_type         bus_results_q [$];

   int send_pct = 0;
   int stall_pct = 0;
   int line_pct = 50;
   int tick_pct = 100;
   int errors = 0;
   int n_items = 0;
   int n_checked = 0;
   int n_started = 0;
   int n_rejected = 0;
   int n_settings = 0;
   int quiet_cycles = 0;

   task automatic report_error(input string msg);
      if (errors < MAX_REPORTS)
         $display("ERROR at %0t: %s", $realtime, msg);
      errors++;
   endtask

   function automatic void enter_phase(input owb_phase_type p, input logic [15:0] ticks);
      ph = p;
      slot_left = ticks;
   endfunction

   function automatic void start_write_slot();
      enter_phase(PHASE_W_LOW, shreg[0] ? timing[CSR_WRITE_ONE_LOW] : timing[CSR_WRITE_ZERO]);
   endfunction

   // Leaves the timed phase that has just run out; returns 1 when the operation ends.
   function automatic logic close_phase(input logic line);
      logic finished;
      finished = 1'b0;
      case (ph)
         PHASE_RST_LOW: enter_phase(PHASE_PRES_WAIT, timing[CSR_PRESENCE_WAIT]);
         PHASE_PRES_WAIT: enter_phase(PHASE_PRES_WIN, timing[CSR_PRESENCE_WIN]);
         PHASE_PRES_WIN: begin
            enter_phase(PHASE_IDLE, 16'd0);
            finished = 1'b1;
         end
         PHASE_W_LOW: enter_phase(PHASE_W_HIGH, shreg[0] ? timing[CSR_WRITE_ONE_HI] : 16'd1);
         PHASE_W_HIGH: begin
            shreg = shreg >> 1;
            if (bits_rem <= 4'd1) begin
               bits_rem = 4'd0;
               enter_phase(PHASE_IDLE, 16'd0);
               finished = 1'b1;
            end else begin
               bits_rem = bits_rem - 4'd1;
               start_write_slot();
            end
         end
         PHASE_R_LOW: enter_phase(PHASE_R_SAMPLE, timing[CSR_READ_SAMPLE]);
         PHASE_R_SAMPLE: begin
            shreg = {line, shreg[7:1]};
            enter_phase(PHASE_R_TAIL, timing[CSR_READ_TAIL]);
         end
         PHASE_R_TAIL: begin
            if (bits_rem <= 4'd1) begin
               bits_rem = 4'd0;
               enter_phase(PHASE_IDLE, 16'd0);
               finished = 1'b1;
            end else begin
               bits_rem = bits_rem - 4'd1;
               enter_phase(PHASE_R_LOW, 16'(READ_LOW_TICKS));
            end
         end
         default: enter_phase(PHASE_IDLE, 16'd0);
      endcase
      return finished;
   endfunction

   function automatic owb_rsp_type bus_step(input owb_req_type it);
      owb_rsp_type r;
      logic done;
      logic rej;
      done = 1'b0;
      rej = 1'b0;
      if (ph == PHASE_IDLE) begin
         case (it.opcode)
            OP_RESET: begin
               last_op = OP_RESET;
               pres_seen = 1'b0;
               enter_phase(PHASE_RST_LOW, timing[CSR_RESET_LOW]);
               n_started++;
            end
            OP_WRITE: begin
               last_op = OP_WRITE;
               shreg = it.write_data;
               bits_rem = 4'd8;
               start_write_slot();
               n_started++;
            end
            OP_READ: begin
               last_op = OP_READ;
               shreg = 8'h00;
               bits_rem = 4'd8;
               enter_phase(PHASE_R_LOW, 16'(READ_LOW_TICKS));
               n_started++;
            end
            default: ;
         endcase
      end else begin
         rej = (it.opcode != OP_NONE);
         // Presence counts on every cycle of the window, ticking or not.
         if (ph == PHASE_PRES_WIN && !it.line_level)
            pres_seen = 1'b1;
         if (it.tick) begin
            if (slot_left <= 16'd1)
               done = close_phase(it.line_level);
            else
               slot_left = slot_left - 16'd1;
         end
      end
      if (rej)
         n_rejected++;
      r.drive_low = (ph == PHASE_RST_LOW) || (ph == PHASE_W_LOW) || (ph == PHASE_R_LOW);
      r.busy_res = (ph != PHASE_IDLE);
      r.done_res = done;
      r.read_byte = (ph == PHASE_IDLE && last_op == OP_READ) ? shreg : 8'h00;
      r.presence = pres_seen;
      r.rejected = rej;
      return r;
   endfunction

   function automatic logic ends_operation(input logic tk);
      return tk && (slot_left <= 16'd1) && ((ph == PHASE_PRES_WIN) ||
             ((ph == PHASE_W_HIGH || ph == PHASE_R_TAIL) && bits_rem <= 4'd1));
   endfunction

   // Builds the next bus cycle from the shadow state: commands while idle,
   // mostly plain cycles while an operation runs.
   function automatic owb_req_type pick_item(input int cmd_pct, input int rej_pct);
      owb_req_type it;
      it.write_data = 8'($urandom_range(255));
      it.tick = ($urandom_range(99) < tick_pct);
      it.line_level = ($urandom_range(99) < line_pct);
      it.opcode = OP_NONE;
      if (ph == PHASE_IDLE) begin
         if ($urandom_range(99) < cmd_pct)
            it.opcode = owb_op_type'($urandom_range(1, 3));
      end else if (rej_pct > 0) begin
         if ($urandom_range(99) < rej_pct ||
             (ends_operation(it.tick) && $urandom_range(99) < 30))
            it.opcode = owb_op_type'($urandom_range(1, 3));
      end
      return it;
   endfunction

   task automatic send_item(input owb_req_type it);
      while (send_pct > 0 && $urandom_range(99) < send_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= it;
      do
         @(posedge clock);
      while (req_stall);
      bus_results_q.push_back(bus_step(it));
      n_items++;
      @(negedge clock);
   endtask

   // Runs the current operation out and waits until every result is back.
   task automatic quiesce();
      owb_req_type it;
      while (ph != PHASE_IDLE) begin
         it = '0;
         it.tick = 1'b1;
         it.line_level = 1'($urandom_range(1));
         send_item(it);
      end
      req_valid <= 1'b0;
      while (bus_results_q.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(input owb_csr_index_type idx, input logic [15:0] val);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_write_data <= val;
      timing[idx] = val;
      @(negedge clock);
      csr_write_en <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_all_timing(input logic [15:0] val);
      quiesce();
      for (int i = 0; i < 8; i++)
         write_csr(owb_csr_index_type'(i), val);
      n_settings++;
   endtask

   task automatic run_op(input owb_op_type op, input logic [7:0] data, input int line_p,
                         input int tick_p, input int rej_p);
      owb_req_type it;
      line_pct = line_p;
      tick_pct = tick_p;
      it = pick_item(0, 0);
      it.opcode = op;
      it.write_data = data;
      send_item(it);
      while (ph != PHASE_IDLE)
         send_item(pick_item(0, rej_p));
   endtask

   // The read slot is the shortest operation under the reset timings.
   task automatic test_default_timing();
      run_op(OP_READ, 8'h00, 50, 100, 0);
   endtask

   task automatic test_minimum_timing();
      set_all_timing(16'd1);
      run_op(OP_RESET, 8'h00, 100, 100, 0);
      run_op(OP_RESET, 8'h00, 0, 100, 0);
      run_op(OP_WRITE, 8'h00, 50, 100, 0);
      run_op(OP_WRITE, 8'hFF, 50, 100, 0);
      run_op(OP_READ, 8'h00, 0, 100, 0);
      run_op(OP_READ, 8'h00, 100, 100, 0);
      run_op(OP_READ, 8'h00, 50, 100, 0);
   endtask

   // A duration of zero behaves as one tick.
   task automatic test_zero_timing();
      set_all_timing(16'd0);
      run_op(OP_RESET, 8'h00, 50, 50, 0);
      run_op(OP_WRITE, 8'hA5, 50, 50, 0);
      run_op(OP_READ, 8'h00, 50, 50, 0);
   endtask

   task automatic test_busy_commands();
      set_all_timing(16'd2);
      run_op(OP_RESET, 8'h00, 50, 70, 40);
      run_op(OP_WRITE, 8'h3C, 50, 70, 40);
      run_op(OP_READ, 8'h00, 50, 70, 40);
   endtask

   task automatic test_long_timing();
      set_all_timing(16'd1);
      write_csr(CSR_RESET_LOW, 16'd64);
      write_csr(CSR_WRITE_ONE_HI, 16'd64);
      run_op(OP_RESET, 8'h00, 100, 100, 0);
      run_op(OP_WRITE, 8'h01, 50, 100, 0);
   endtask

   function automatic logic [15:0] pick_timing();
      int r;
      r = $urandom_range(99);
      if (r < 10)
         return 16'd0;
      else if (r < 70)
         return 16'($urandom_range(1, 3));
      else if (r < 95)
         return 16'($urandom_range(4, 12));
      return 16'($urandom_range(13, 40));
   endfunction

   task automatic test_random_traffic(input int n_per_setting);
      owb_req_type it;
      int tick_choice [3];
      tick_choice[0] = 100;
      tick_choice[1] = 60;
      tick_choice[2] = 25;
      for (int mode = 0; mode < 4; mode++) begin
         for (int s = 0; s < 3; s++) begin
            quiesce();
            for (int i = 0; i < 8; i++)
               write_csr(owb_csr_index_type'(i), pick_timing());
            n_settings++;
            case (mode)
               0: begin send_pct = 0;  stall_pct = 0;  end
               1: begin send_pct = 59; stall_pct = 0;  end
               2: begin send_pct = 0;  stall_pct = 59; end
               default: begin send_pct = 12; stall_pct = 12; end
            endcase
            tick_pct = tick_choice[s];
            for (int n = 0; n < n_per_setting; n++) begin
               it = pick_item(80, 5);
               if (ph == PHASE_IDLE && it.opcode != OP_NONE)
                  line_pct = $urandom_range(4) * 25;
               send_item(it);
            end
         end
      end
      quiesce();
      send_pct = 0;
      stall_pct = 0;
   endtask

   always @(negedge clock)
      rsp_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);

   always @(posedge clock) begin
      owb_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (bus_results_q.size() == 0) begin
            report_error("result with nothing expected");
         end else begin
            want = bus_results_q.pop_front();
            n_checked++;
            if (rsp_data.drive_low !== want.drive_low)
               report_error($sformatf("drive_low got %b want %b",
                                      rsp_data.drive_low, want.drive_low));
            if (rsp_data.busy_res !== want.busy_res)
               report_error($sformatf("busy_res got %b want %b",
                                      rsp_data.busy_res, want.busy_res));
            if (rsp_data.done_res !== want.done_res)
               report_error($sformatf("done_res got %b want %b",
                                      rsp_data.done_res, want.done_res));
            if (rsp_data.read_byte !== want.read_byte)
               report_error($sformatf("read_byte got %h want %h",
                                      rsp_data.read_byte, want.read_byte));
            if (rsp_data.presence !== want.presence)
               report_error($sformatf("presence got %b want %b",
                                      rsp_data.presence, want.presence));
            if (rsp_data.rejected !== want.rejected)
               report_error($sformatf("rejected got %b want %b",
                                      rsp_data.rejected, want.rejected));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
         $display("Watchdog expired with %0d results outstanding.", bus_results_q.size());
         $display("tb_top NOT OK");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      ph = PHASE_IDLE;
      slot_left = 16'd0;
      shreg = 8'h00;
      bits_rem = 4'd0;
      last_op = OP_NONE;
      pres_seen = 1'b0;
      timing[CSR_RESET_LOW] = RESET_LOW_DEFAULT;
      timing[CSR_PRESENCE_WAIT] = PRESENCE_WAIT_DEFAULT;
      timing[CSR_PRESENCE_WIN] = PRESENCE_WIN_DEFAULT;
      timing[CSR_WRITE_ZERO] = WRITE_ZERO_DEFAULT;
      timing[CSR_WRITE_ONE_LOW] = WRITE_ONE_LOW_DEFAULT;
      timing[CSR_WRITE_ONE_HI] = WRITE_ONE_HIGH_DEFAULT;
      timing[CSR_READ_SAMPLE] = READ_SAMPLE_DEFAULT;
      timing[CSR_READ_TAIL] = READ_TAIL_DEFAULT;
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_default_timing();
      test_minimum_timing();
      test_zero_timing();
      test_busy_commands();
      test_long_timing();
      test_random_traffic(15);

      quiesce();
      repeat (10) @(negedge clock);
      if (bus_results_q.size() != 0)
         report_error($sformatf("%0d results never arrived", bus_results_q.size()));
      $display("Sent %0d bus cycles and checked %0d results over %0d timing settings.",
               n_items, n_checked, n_settings + 1);
      $display("Started %0d operations; %0d commands were refused while busy.",
               n_started, n_rejected);
      if (errors == 0)
         $display("tb_top OK");
      else
         $display("tb_top NOT OK");
      $finish;
   end

endmodule

// ===== one_wire_bus_master.f =====
hw/rtl/owb_pkg.sv
hw/rtl/owb_csr.sv
hw/rtl/owb_core.sv
hw/rtl/one_wire_bus_master.sv
dv/tb_top.sv
